// ===== hw/rtl/ipv4_l4_checksum_engine_macros.svh =====
// Assertion macros for the checksum engine checker.
`ifndef IPV4_L4_CHECKSUM_ENGINE_MACROS_SVH
`define IPV4_L4_CHECKSUM_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define IPV4CS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ipv4cs assertion failed");

// Next-cycle implication, disabled while in reset.
`define IPV4CS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ipv4cs assertion failed");

`endif

// ===== hw/rtl/ipv4cs_pkg.sv =====
// Shared types, codes and helpers for the IPv4 checksum engine.
package ipv4cs_pkg;

    localparam int unsigned FIFO_DEPTH_DEF = 4;
    localparam logic [15:0] MAX_LEN_RESET  = 16'hFFFF;

    // Result status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NOT_IPV4    = 3'd1;
    localparam logic [2:0] ST_HDR_SHORT   = 3'd2;
    localparam logic [2:0] ST_TOO_LONG    = 3'd3;
    localparam logic [2:0] ST_TOTAL_SHORT = 3'd4;
    localparam logic [2:0] ST_UDP_BAD     = 3'd5;
    localparam logic [2:0] ST_TRUNCATED   = 3'd6;

    // Transport kind codes
    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_TCP   = 2'd1;
    localparam logic [1:0] KIND_UDP   = 2'd2;
    localparam logic [1:0] KIND_ICMP  = 2'd3;

    // IP protocol numbers
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    // One queued operation from the front end to the accumulator
    typedef struct packed {
        logic        hdr_en;
        logic        pay_en;
        logic [15:0] word;
        logic        eop;
        logic [2:0]  status;
        logic [1:0]  kind;
        logic [16:0] extra;
    } ipv4cs_op_t;

    // One's-complement sum of two words and a 17-bit extra term
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b,
                                           input logic [16:0] c);
        logic [17:0] s;
        logic [16:0] f;
        s = {2'b00, a} + {2'b00, b} + {1'b0, c};
        f = {1'b0, s[15:0]} + {15'd0, s[17:16]};
        return f[15:0] + {15'd0, f[16]};
    endfunction

endpackage

// ===== hw/rtl/ipv4cs_front.sv =====
// Front end: byte parsing, field capture, error checks and op generation.
module ipv4cs_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [15:0]            max_packet_length,
    input  logic                   in_valid,
    input  logic [7:0]             data_byte,
    input  logic                   end_of_packet,
    input  logic                   q_full,
    output logic                   q_push,
    output ipv4cs_pkg::ipv4cs_op_t q_op
);

    logic [15:0] max_len_reg, max_len_next;
    logic [15:0] pos_reg, pos_next;
    logic [5:0]  hlen_reg, hlen_next;
    logic [15:0] tlen_reg, tlen_next;
    logic [7:0]  proto_reg, proto_next;
    logic [15:0] ulen_reg, ulen_next;
    logic [15:0] seg_reg, seg_next;
    logic [2:0]  err_reg, err_next;

    logic        accept;
    logic [5:0]  hl_cur;
    logic [15:0] tl_lo;
    logic [15:0] ul_lo;
    logic [15:0] off;
    logic [16:0] rcv;
    logic        hdr_en, pay_en;
    logic [2:0]  st;
    logic [1:0]  kind;
    logic [16:0] extra;

    assign accept = in_valid && !q_full;
    assign hl_cur = (pos_reg == 16'd0) ? {data_byte[3:0], 2'b00} : hlen_reg;
    assign tl_lo  = {tlen_reg[15:8], data_byte};
    assign ul_lo  = {ulen_reg[15:8], data_byte};
    assign off    = pos_reg - {10'd0, hlen_reg};
    assign rcv    = {1'b0, pos_reg} + 17'd1;

    assign max_len_next = cfg_valid ? max_packet_length : max_len_reg;

    always_comb
    begin
        hlen_next  = hlen_reg;
        tlen_next  = tlen_reg;
        proto_next = proto_reg;
        ulen_next  = ulen_reg;
        seg_next   = seg_reg;
        err_next   = err_reg;
        hdr_en     = 1'b0;
        pay_en     = 1'b0;
        if (err_reg == ipv4cs_pkg::ST_OK)
        begin
            if (pos_reg == 16'd0 && data_byte[7:4] != 4'h4)
            begin
                err_next = ipv4cs_pkg::ST_NOT_IPV4;
            end
            else if (pos_reg == 16'd0 && hl_cur < 6'd20)
            begin
                hlen_next = hl_cur;
                err_next  = ipv4cs_pkg::ST_HDR_SHORT;
            end
            else if (pos_reg >= 16'd4 && pos_reg >= tlen_reg)
            begin
                // past total length: ignored
            end
            else if (pos_reg == 16'd3 && tl_lo > max_len_reg)
            begin
                tlen_next = tl_lo;
                err_next  = ipv4cs_pkg::ST_TOO_LONG;
            end
            else if (pos_reg == 16'd3 && tl_lo < {10'd0, hlen_reg})
            begin
                tlen_next = tl_lo;
                err_next  = ipv4cs_pkg::ST_TOTAL_SHORT;
            end
            else
            begin
                if (pos_reg == 16'd0)
                begin
                    hlen_next = hl_cur;
                end
                if (pos_reg == 16'd2)
                begin
                    tlen_next = {data_byte, 8'h00};
                end
                if (pos_reg == 16'd3)
                begin
                    tlen_next = tl_lo;
                    seg_next  = tl_lo - {10'd0, hlen_reg};
                end
                if (pos_reg == 16'd9)
                begin
                    proto_next = data_byte;
                end
                if (pos_reg < {10'd0, hl_cur})
                begin
                    hdr_en = (pos_reg != 16'd10) && (pos_reg != 16'd11);
                    pay_en = (pos_reg >= 16'd12) && (pos_reg < 16'd20) &&
                             (proto_reg == ipv4cs_pkg::PROTO_TCP ||
                              proto_reg == ipv4cs_pkg::PROTO_UDP);
                end
                else
                begin
                    case (proto_reg)
                        ipv4cs_pkg::PROTO_TCP:
                        begin
                            pay_en = (off != 16'd16) && (off != 16'd17);
                        end
                        ipv4cs_pkg::PROTO_UDP:
                        begin
                            if (off == 16'd5 && (ul_lo < 16'd8 || ul_lo > seg_reg))
                            begin
                                err_next = ipv4cs_pkg::ST_UDP_BAD;
                            end
                            else
                            begin
                                if (off == 16'd4)
                                begin
                                    ulen_next = {data_byte, 8'h00};
                                end
                                if (off == 16'd5)
                                begin
                                    ulen_next = ul_lo;
                                end
                                pay_en = (off < 16'd6) ||
                                         (off < ulen_reg && off != 16'd6 && off != 16'd7);
                            end
                        end
                        ipv4cs_pkg::PROTO_ICMP:
                        begin
                            pay_en = (off != 16'd2) && (off != 16'd3);
                        end
                        default:
                        begin
                            pay_en = 1'b0;
                        end
                    endcase
                end
            end
        end
    end

    // End-of-packet status, kind and pseudo-header term
    always_comb
    begin
        st = err_next;
        if (st == ipv4cs_pkg::ST_OK && (rcv < 17'd4 || rcv < {1'b0, tlen_next}))
        begin
            st = ipv4cs_pkg::ST_TRUNCATED;
        end
        if (st == ipv4cs_pkg::ST_OK && proto_reg == ipv4cs_pkg::PROTO_UDP &&
            seg_reg < 16'd8)
        begin
            st = ipv4cs_pkg::ST_UDP_BAD;
        end
        kind  = ipv4cs_pkg::KIND_OTHER;
        extra = 17'd0;
        case (proto_reg)
            ipv4cs_pkg::PROTO_TCP:
            begin
                kind  = ipv4cs_pkg::KIND_TCP;
                extra = {1'b0, seg_reg} + 17'd6;
            end
            ipv4cs_pkg::PROTO_UDP:
            begin
                kind  = ipv4cs_pkg::KIND_UDP;
                extra = {1'b0, ulen_reg} + 17'd17;
            end
            ipv4cs_pkg::PROTO_ICMP:
            begin
                kind = ipv4cs_pkg::KIND_ICMP;
            end
            default:
            begin
                kind = ipv4cs_pkg::KIND_OTHER;
            end
        endcase
        if (st != ipv4cs_pkg::ST_OK)
        begin
            kind = ipv4cs_pkg::KIND_OTHER;
        end
    end

    assign pos_next = (pos_reg == 16'hFFFF) ? pos_reg : pos_reg + 16'd1;

    assign q_push        = accept && (hdr_en || pay_en || end_of_packet);
    assign q_op.hdr_en   = hdr_en;
    assign q_op.pay_en   = pay_en;
    assign q_op.word     = pos_reg[0] ? {8'h00, data_byte} : {data_byte, 8'h00};
    assign q_op.eop      = end_of_packet;
    assign q_op.status   = st;
    assign q_op.kind     = kind;
    assign q_op.extra    = end_of_packet ? extra : 17'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= ipv4cs_pkg::MAX_LEN_RESET;
            pos_reg     <= '0;
            hlen_reg    <= '0;
            tlen_reg    <= '0;
            proto_reg   <= '0;
            ulen_reg    <= '0;
            seg_reg     <= '0;
            err_reg     <= ipv4cs_pkg::ST_OK;
        end
        else
        begin
            max_len_reg <= max_len_next;
            if (accept && end_of_packet)
            begin
                pos_reg   <= '0;
                hlen_reg  <= '0;
                tlen_reg  <= '0;
                proto_reg <= '0;
                ulen_reg  <= '0;
                seg_reg   <= '0;
                err_reg   <= ipv4cs_pkg::ST_OK;
            end
            else if (accept)
            begin
                pos_reg   <= pos_next;
                hlen_reg  <= hlen_next;
                tlen_reg  <= tlen_next;
                proto_reg <= proto_next;
                ulen_reg  <= ulen_next;
                seg_reg   <= seg_next;
                err_reg   <= err_next;
            end
        end
    end

endmodule

// ===== hw/rtl/ipv4cs_fifo.sv =====
// Small register queue between the front end and the accumulator.
module ipv4cs_fifo
#(
    parameter int unsigned DEPTH = ipv4cs_pkg::FIFO_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  ipv4cs_pkg::ipv4cs_op_t wdata,
    input  logic                   pop,
    output logic                   full,
    output logic                   not_empty,
    output ipv4cs_pkg::ipv4cs_op_t rdata
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    ipv4cs_pkg::ipv4cs_op_t mem_reg [DEPTH];
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == FULL_CNT);
    assign not_empty = (cnt_reg != '0);
    assign rdata     = mem_reg[rptr_reg];

    assign wptr_next = push ? ((wptr_reg == LAST) ? '0 : wptr_reg + 1'b1) : wptr_reg;
    assign rptr_next = pop  ? ((rptr_reg == LAST) ? '0 : rptr_reg + 1'b1) : rptr_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ===== hw/rtl/ipv4cs_back.sv =====
// Back end: one's-complement accumulation and result register.
module ipv4cs_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  ipv4cs_pkg::ipv4cs_op_t q_op,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [2:0]             status,
    output logic [15:0]            ip_header_checksum,
    output logic [15:0]            transport_checksum,
    output logic [1:0]             transport_kind
);

    logic [15:0] hacc_reg, hacc_next;
    logic [15:0] pacc_reg, pacc_next;
    logic        ovalid_reg, ovalid_next;
    logic [2:0]  st_reg;
    logic [15:0] hck_reg, tck_reg;
    logic [1:0]  kind_reg;
    logic [15:0] hsum, psum;
    logic        ok;

    assign q_pop = q_valid && (!q_op.eop || !ovalid_reg || !out_stall);

    assign hsum = ipv4cs_pkg::oc_add(hacc_reg, q_op.hdr_en ? q_op.word : 16'd0, 17'd0);
    assign psum = ipv4cs_pkg::oc_add(pacc_reg, q_op.pay_en ? q_op.word : 16'd0, q_op.extra);
    assign ok   = (q_op.status == ipv4cs_pkg::ST_OK);

    always_comb
    begin
        hacc_next   = hacc_reg;
        pacc_next   = pacc_reg;
        ovalid_next = ovalid_reg && out_stall;
        if (q_pop)
        begin
            if (q_op.eop)
            begin
                hacc_next   = '0;
                pacc_next   = '0;
                ovalid_next = 1'b1;
            end
            else
            begin
                hacc_next = hsum;
                pacc_next = psum;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && q_op.eop)
        begin
            st_reg   <= q_op.status;
            kind_reg <= q_op.kind;
            hck_reg  <= ok ? ~hsum : 16'd0;
            tck_reg  <= (ok && q_op.kind != ipv4cs_pkg::KIND_OTHER) ? ~psum : 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hacc_reg   <= '0;
            pacc_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            hacc_reg   <= hacc_next;
            pacc_reg   <= pacc_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid          = ovalid_reg;
    assign status             = st_reg;
    assign ip_header_checksum = hck_reg;
    assign transport_checksum = tck_reg;
    assign transport_kind     = kind_reg;

endmodule

// ===== hw/rtl/ipv4_l4_checksum_engine.sv =====
// Top level of the IPv4 header and TCP/UDP/ICMP checksum engine.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_stall  | data_byte, end_of_packet
//  out      | out_valid / out_stall| status, ip_header_checksum,
//           |                      | transport_checksum, transport_kind
//  cfg      | cfg_valid / cfg_ready| max_packet_length
//
//  One byte request per cycle while in_stall is low; the parser decides per byte what
//  it adds and pushes an op into a FIFO_DEPTH queue, the accumulator drains one op per
//  cycle unless the end-of-packet op waits on a result held by out_stall. out_valid
//  rises once that op has left the queue and its result is registered. in_stall rises
//  only when the queue is full, which happens only while out_stall holds the result.
//  Reset is asynchronous, active low; max_packet_length resets to 65535.
//  cfg_ready is always high; writes are expected only while the engine is idle.
module ipv4_l4_checksum_engine
#(
    parameter int unsigned FIFO_DEPTH = ipv4cs_pkg::FIFO_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] max_packet_length,
    // byte stream in
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_packet,
    // per-packet result out
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [15:0] ip_header_checksum,
    output logic [15:0] transport_checksum,
    output logic [1:0]  transport_kind
);

    ipv4cs_pkg::ipv4cs_op_t push_op;
    ipv4cs_pkg::ipv4cs_op_t head_op;
    logic q_push, q_pop, q_full, q_not_empty;

    assign cfg_ready = 1'b1;
    // Stall is taken straight from the queue's registered fill state.
    assign in_stall  = q_full;

    ipv4cs_front u_front
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .max_packet_length (max_packet_length),
        .in_valid          (in_valid),
        .data_byte         (data_byte),
        .end_of_packet     (end_of_packet),
        .q_full            (q_full),
        .q_push            (q_push),
        .q_op              (push_op)
    );

    ipv4cs_fifo
    #(
        .DEPTH (FIFO_DEPTH)
    )
    u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wdata     (push_op),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .rdata     (head_op)
    );

    // Accumulator clears its sums on the end-of-packet op and loads the result.
    ipv4cs_back u_back
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .q_valid            (q_not_empty),
        .q_op               (head_op),
        .q_pop              (q_pop),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .status             (status),
        .ip_header_checksum (ip_header_checksum),
        .transport_checksum (transport_checksum),
        .transport_kind     (transport_kind)
    );

endmodule

// ===== hw/rtl/ipv4cs_checker.sv =====
// Port-level checker for the checksum engine, bound to the top level.
`include "ipv4_l4_checksum_engine_macros.svh"

module ipv4cs_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  status,
    input logic [15:0] ip_header_checksum,
    input logic [15:0] transport_checksum,
    input logic [1:0]  transport_kind
);

    // held status and checksums stay put
    `IPV4CS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(ip_header_checksum) && $stable(transport_checksum))

    // an error result carries no checksums and no kind
    `IPV4CS_ASSERT_NOW(a_err_zero, clk, rst_n, out_valid && status != ipv4cs_pkg::ST_OK, ip_header_checksum == 16'd0 && transport_checksum == 16'd0 && transport_kind == ipv4cs_pkg::KIND_OTHER)

    // other protocols get no transport checksum
    `IPV4CS_ASSERT_NOW(a_other_zero, clk, rst_n, out_valid && transport_kind == ipv4cs_pkg::KIND_OTHER, transport_checksum == 16'd0)

endmodule

bind ipv4_l4_checksum_engine ipv4cs_checker u_ipv4cs_checker
(
    .clk                (clk),
    .rst_n              (rst_n),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .status             (status),
    .ip_header_checksum (ip_header_checksum),
    .transport_checksum (transport_checksum),
    .transport_kind     (transport_kind)
);

// ===== test/ipv4_l4_checksum_engine_test.sv =====
// Self-checking testbench for the IPv4 header and TCP/UDP/ICMP checksum engine.
`timescale 1ns / 1ps

module ipv4_l4_checksum_engine_test;

    import ipv4cs_pkg::*;

    localparam int          CYCLE_LIMIT    = 500_000;
    localparam int          SETTLE_CYCLES  = 10;    // result register plus the op queue
    localparam int          RANDOM_BYTES   = 400;
    localparam int          RANDOM_PACKETS = 8;
    localparam int          MAX_PRINTS     = 100;
    localparam logic [7:0]  VERSION_MASK   = 8'hf0;
    localparam logic [7:0]  IPV4_VERSION   = 8'h40;
    localparam logic [7:0]  IHL_MASK       = 8'h0f;
    localparam logic [15:0] POSITION_MAX   = 16'hffff;

    typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

    // One per-packet result as the engine reports it
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] ip_csum;
        logic [15:0] l4_csum;
        logic [1:0]  kind;
    } packet_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] max_packet_length = 16'hffff;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        end_of_packet = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [15:0] ip_header_checksum;
    logic [15:0] transport_checksum;
    logic [1:0]  transport_kind;

    // Predicted packet state, cleared after every final byte
    logic [15:0] seen_bytes = '0;
    logic [5:0]  hdr_bytes = '0;
    logic [15:0] ip_total = '0;
    logic [7:0]  ip_proto = '0;
    logic [15:0] udp_total = '0;
    logic [31:0] hdr_sum = '0;
    logic [31:0] l4_sum = '0;
    logic [2:0]  pkt_error = ST_OK;
    logic [15:0] max_len_setting = MAX_LEN_RESET;

    packet_result_t packet_results_due[$];
    logic [7:0]     frame[$];

    int  mismatch_count = 0;
    int  bytes_sent = 0;
    int  packets_sent = 0;
    int  cycle_count = 0;
    int  hold_left = 0;     // long receiver hold-off, counted down by the stall process
    int  stall_left = 0;
    bit  calm = 1'b0;       // no idle bursts on either side while set

    ipv4_l4_checksum_engine dut
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .max_packet_length  (max_packet_length),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .data_byte          (data_byte),
        .end_of_packet      (end_of_packet),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .status             (status),
        .ip_header_checksum (ip_header_checksum),
        .transport_checksum (transport_checksum),
        .transport_kind     (transport_kind)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("ipv4_l4_checksum_engine_test: FAIL");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Checksum prediction
    //------------------------------------------------------------------

    // Fold the carries of a one's-complement sum back in and invert.
    function automatic logic [15:0] fold_and_invert(input logic [31:0] sum);
        logic [31:0] c;
        c = sum[31:16] + sum[15:0];
        c = c + (c >> 16);
        return ~c[15:0];
    endfunction

    // Field capture, error checks and sum updates for one byte of a clean packet.
    task absorb_byte(input logic [15:0] pos, input logic [7:0] b);
        logic [15:0] word;
        logic [15:0] off;
        logic        pseudo;
        word = pos[0] ? {8'h00, b} : {b, 8'h00};
        pseudo = (ip_proto == PROTO_TCP) || (ip_proto == PROTO_UDP);
        if (pos == 16'd0)
        begin
            if ((b & VERSION_MASK) != IPV4_VERSION)
            begin
                pkt_error = ST_NOT_IPV4;
                return;
            end
            hdr_bytes = 6'((b & IHL_MASK) << 2);
            if (hdr_bytes < 6'd20)
            begin
                pkt_error = ST_HDR_SHORT;
                return;
            end
        end
        // past the total length everything is ignored
        if (pos >= 16'd4 && pos >= ip_total)
            return;
        if (pos == 16'd2)
            ip_total = {b, 8'h00};
        if (pos == 16'd3)
        begin
            ip_total[7:0] = b;
            if (ip_total > max_len_setting)
            begin
                pkt_error = ST_TOO_LONG;
                return;
            end
            if (ip_total < hdr_bytes)
            begin
                pkt_error = ST_TOTAL_SHORT;
                return;
            end
        end
        if (pos == 16'd9)
            ip_proto = b;

        if (pos < hdr_bytes)
        begin
            // header checksum field counts as zero; addresses feed the pseudo-header
            if (pos != 16'd10 && pos != 16'd11)
                hdr_sum += word;
            if (pos >= 16'd12 && pos < 16'd20 && pseudo)
                l4_sum += word;
            return;
        end

        off = pos - hdr_bytes;
        if (ip_proto == PROTO_TCP)
        begin
            if (off != 16'd16 && off != 16'd17)
                l4_sum += word;
        end
        else if (ip_proto == PROTO_UDP)
        begin
            if (off == 16'd4)
                udp_total = {b, 8'h00};
            if (off == 16'd5)
            begin
                udp_total[7:0] = b;
                if (udp_total < 16'd8 || udp_total > ip_total - hdr_bytes)
                begin
                    pkt_error = ST_UDP_BAD;
                    return;
                end
            end
            if ((off < 16'd6 || off < udp_total) && off != 16'd6 && off != 16'd7)
                l4_sum += word;
        end
        else if (ip_proto == PROTO_ICMP)
        begin
            if (off != 16'd2 && off != 16'd3)
                l4_sum += word;
        end
    endtask

    // Advance the prediction by one accepted byte; the final byte yields a result.
    task predict_byte(input logic [7:0] b, input logic last);
        logic [15:0]    pos;
        logic [16:0]    received;
        packet_result_t res;
        pos = seen_bytes;
        if (pkt_error == ST_OK)
            absorb_byte(pos, b);
        if (seen_bytes != POSITION_MAX)
            seen_bytes = pos + 16'd1;
        if (!last)
            return;

        received = {1'b0, pos} + 17'd1;
        res = '0;
        res.status = pkt_error;
        if (res.status == ST_OK && (received < 17'd4 || received < {1'b0, ip_total}))
            res.status = ST_TRUNCATED;
        if (res.status == ST_OK && ip_proto == PROTO_UDP && (ip_total - hdr_bytes) < 16'd8)
            res.status = ST_UDP_BAD;
        if (res.status == ST_OK)
        begin
            res.ip_csum = fold_and_invert(hdr_sum);
            case (ip_proto)
                PROTO_TCP:
                begin
                    res.kind = KIND_TCP;
                    res.l4_csum = fold_and_invert(l4_sum + 32'd6 + (ip_total - hdr_bytes));
                end
                PROTO_UDP:
                begin
                    res.kind = KIND_UDP;
                    res.l4_csum = fold_and_invert(l4_sum + 32'd17 + udp_total);
                end
                PROTO_ICMP:
                begin
                    res.kind = KIND_ICMP;
                    res.l4_csum = fold_and_invert(l4_sum);
                end
                default:
                    res.kind = KIND_OTHER;
            endcase
        end
        packet_results_due.push_back(res);

        seen_bytes = '0;
        hdr_bytes = '0;
        ip_total = '0;
        ip_proto = '0;
        udp_total = '0;
        hdr_sum = '0;
        l4_sum = '0;
        pkt_error = ST_OK;
    endtask

    //------------------------------------------------------------------
    // Result checking
    //------------------------------------------------------------------

    task flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    always @(posedge clk)
    begin : check_results
        packet_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (packet_results_due.size() == 0)
                flag_mismatch($sformatf("result with none due, status %0d", status));
            else
            begin
                want = packet_results_due.pop_front();
                if (status !== want.status)
                    flag_mismatch($sformatf("status %0d, want %0d", status, want.status));
                if (ip_header_checksum !== want.ip_csum)
                    flag_mismatch($sformatf("ip_header_checksum %h, want %h",
                                            ip_header_checksum, want.ip_csum));
                if (transport_checksum !== want.l4_csum)
                    flag_mismatch($sformatf("transport_checksum %h, want %h",
                                            transport_checksum, want.l4_csum));
                if (transport_kind !== want.kind)
                    flag_mismatch($sformatf("transport_kind %0d, want %0d",
                                            transport_kind, want.kind));
            end
        end
    end

    // Receiver: random stall bursts, or a long hold-off when one is requested
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else if (!calm && $urandom_range(0, 6) == 0)
        begin
            out_stall <= 1'b1;
            stall_left = $urandom_range(0, 4);
        end
        else
            out_stall <= 1'b0;
    end

    //------------------------------------------------------------------
    // Sender side
    //------------------------------------------------------------------

    // Offer one byte request, optionally after an idle burst, and wait for acceptance.
    task send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 5);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        data_byte <= b;
        end_of_packet <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_byte(b, last);
        bytes_sent++;
        if (last)
            packets_sent++;
    endtask

    task send_frame();
        for (int i = 0; i < frame.size(); i++)
            send_byte(frame[i], i == frame.size() - 1);
    endtask

    // Lower valid and wait until every predicted result has come out.
    task drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (packet_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task set_max_length(input logic [15:0] value);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        max_packet_length <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        max_len_setting = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Well-formed packet of total length ihl_words*4 + seg_len; header fields
    // are consistent, everything else follows the fill pattern.
    task build_frame(input int ihl_words, input int seg_len, input logic [7:0] proto,
                     input int udp_field, input fill_t fill);
        int total;
        int hdr;
        total = ihl_words * 4 + seg_len;
        hdr = ihl_words * 4;
        frame.delete();
        for (int i = 0; i < total; i++)
        begin
            case (fill)
                FILL_ZERO: frame.push_back(8'h00);
                FILL_ONES: frame.push_back(8'hff);
                default:   frame.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        frame[0] = IPV4_VERSION | (8'(ihl_words) & IHL_MASK);
        if (total > 3)
        begin
            frame[2] = 8'(total >> 8);
            frame[3] = 8'(total);
        end
        if (total > 9)
            frame[9] = proto;
        if (proto == PROTO_UDP && seg_len >= 6)
        begin
            frame[hdr + 4] = 8'(udp_field >> 8);
            frame[hdr + 5] = 8'(udp_field);
        end
    endtask

    task pad_frame(input int count);
        repeat (count) frame.push_back(8'($urandom_range(0, 255)));
    endtask

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------

    task test_well_formed();
        build_frame(5, 20, PROTO_TCP, 0, FILL_RANDOM);     // full TCP header incl. checksum
        send_frame();
        build_frame(5, 8, PROTO_UDP, 8, FILL_RANDOM);      // empty UDP datagram
        send_frame();
        build_frame(5, 13, PROTO_UDP, 11, FILL_RANDOM);    // odd UDP length, slack after it
        send_frame();
        build_frame(5, 9, PROTO_ICMP, 0, FILL_RANDOM);     // odd ICMP message, zero pad
        send_frame();
        build_frame(5, 4, 8'hff, 0, FILL_RANDOM);          // unknown protocol
        send_frame();
        build_frame(15, 0, PROTO_TCP, 0, FILL_RANDOM);     // largest header, no segment
        send_frame();
        build_frame(6, 30, PROTO_TCP, 0, FILL_ONES);       // carries on every add
        send_frame();
        build_frame(5, 10, PROTO_ICMP, 0, FILL_ZERO);
        send_frame();
        build_frame(5, 12, PROTO_TCP, 0, FILL_RANDOM);     // junk past total length
        pad_frame(5);
        send_frame();
    endtask

    task test_header_errors();
        build_frame(5, 0, PROTO_TCP, 0, FILL_RANDOM);
        frame[0] = 8'h65;                                  // version 6
        send_frame();
        frame = {8'h00};                                   // lone zero byte
        send_frame();
        frame = {8'hff, 8'hff};
        send_frame();
        build_frame(5, 0, PROTO_TCP, 0, FILL_RANDOM);
        frame[0] = 8'h44;                                  // IHL of 4 words
        send_frame();
        frame = {8'h40, 8'h00, 8'h00, 8'h14};              // IHL of zero
        send_frame();
        build_frame(15, 0, PROTO_UDP, 0, FILL_RANDOM);     // total below header
        frame[2] = 8'h00;
        frame[3] = 8'd40;
        send_frame();
    endtask

    task test_udp_length();
        build_frame(5, 12, PROTO_UDP, 7, FILL_RANDOM);     // below 8
        send_frame();
        build_frame(5, 10, PROTO_UDP, 11, FILL_RANDOM);    // beyond the segment
        send_frame();
        build_frame(5, 4, PROTO_UDP, 0, FILL_RANDOM);      // length field never arrives
        send_frame();
        build_frame(5, 7, PROTO_UDP, 7, FILL_RANDOM);      // segment one short of 8
        send_frame();
    endtask

    task test_truncation();
        frame = {8'h45};
        send_frame();
        frame = {8'h45, 8'h00, 8'h00};
        send_frame();
        build_frame(5, 20, PROTO_TCP, 0, FILL_RANDOM);
        frame = frame[0:29];
        send_frame();
    endtask

    task test_max_length();
        set_max_length(16'd0);          // below any legal total: everything too long
        build_frame(5, 0, PROTO_TCP, 0, FILL_RANDOM);
        send_frame();
        set_max_length(16'd19);
        build_frame(5, 0, PROTO_ICMP, 0, FILL_RANDOM);
        send_frame();
        set_max_length(16'd20);
        build_frame(5, 0, PROTO_ICMP, 0, FILL_RANDOM);
        send_frame();
        build_frame(5, 1, PROTO_ICMP, 0, FILL_RANDOM);
        send_frame();
        set_max_length(MAX_LEN_RESET);
        build_frame(5, 1, PROTO_ICMP, 0, FILL_RANDOM);
        send_frame();
    endtask

    // Receiver holds off while short packets keep arriving: the op queue
    // fills and the engine must stall its input without losing a byte.
    task test_back_pressure();
        drain_results();
        calm = 1'b1;
        hold_left = 150;
        repeat (10)
        begin
            build_frame(5, $urandom_range(0, 4), 8'($urandom_range(0, 255)), 0, FILL_RANDOM);
            send_frame();
        end
        drain_results();
        calm = 1'b0;
    endtask

    task random_packet();
        int         ihl;
        int         seg;
        int         udp;
        int         hdr;
        logic [7:0] proto;
        fill_t      fill;
        ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
        seg = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 32);
        hdr = ihl * 4;
        case ($urandom_range(0, 9))
            0, 1, 2: proto = PROTO_TCP;
            3, 4, 5: proto = PROTO_UDP;
            6, 7:    proto = PROTO_ICMP;
            default: proto = 8'($urandom_range(0, 255));
        endcase
        udp = (seg >= 8) ? $urandom_range(8, seg) : seg;
        case ($urandom_range(0, 9))
            0:       fill = FILL_ZERO;
            1:       fill = FILL_ONES;
            default: fill = FILL_RANDOM;
        endcase
        build_frame(ihl, seg, proto, udp, fill);
        // most packets stay clean; the rest are cut, padded or corrupted
        case ($urandom_range(0, 11))
            0: frame = frame[0:$urandom_range(0, frame.size() - 1)];
            1: pad_frame($urandom_range(1, 6));
            2: frame[0] = 8'($urandom_range(0, 255));
            3:
            begin
                frame[2] = 8'($urandom_range(0, 255));
                frame[3] = 8'($urandom_range(0, 255));
            end
            4:
            begin
                if (frame.size() > hdr + 5)
                begin
                    frame[hdr + 4] = 8'($urandom_range(0, 255));
                    frame[hdr + 5] = 8'($urandom_range(0, 255));
                end
            end
            default: ;
        endcase
        send_frame();
    endtask

    task test_random_traffic();
        int first_byte;
        int first_packet;
        first_byte = bytes_sent;
        first_packet = packets_sent;
        while (bytes_sent - first_byte < RANDOM_BYTES ||
               packets_sent - first_packet < RANDOM_PACKETS)
        begin
            case ($urandom_range(0, 6))
                0:       set_max_length(16'd20);
                1:       set_max_length(16'($urandom_range(0, 19)));
                2, 3:    set_max_length(16'($urandom_range(40, 200)));
                default: set_max_length(MAX_LEN_RESET);
            endcase
            repeat (4)
            begin
                // final stretch runs with both sides busy every cycle, save where in_stall holds the sender
                calm = (bytes_sent - first_byte) > (RANDOM_BYTES * 4) / 5;
                random_packet();
            end
        end
        calm = 1'b0;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_well_formed();
        test_header_errors();
        test_udp_length();
        test_truncation();
        test_max_length();
        test_back_pressure();
        test_random_traffic();

        drain_results();
        if (mismatch_count == 0)
            $display("ipv4_l4_checksum_engine_test: PASS");
        else
            $display("ipv4_l4_checksum_engine_test: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/ipv4cs_pkg.sv
hw/rtl/ipv4cs_front.sv
hw/rtl/ipv4cs_fifo.sv
hw/rtl/ipv4cs_back.sv
hw/rtl/ipv4_l4_checksum_engine.sv
hw/rtl/ipv4cs_checker.sv
test/ipv4_l4_checksum_engine_test.sv
